FILE: hw/rtl/prc_pkg.sv
`timescale 1ns / 1ps
// Shared constants, the pipeline payload type and the arctangent table of the point rotator.
package prc_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int ANGLE_WIDTH     = 17;
  localparam int CORDIC_STEPS    = 24;

  // coordinate width plus guard bits is constant, so the datapath width is too
  localparam int GUARD_SUM = 59;
  localparam int XY_WIDTH  = GUARD_SUM + 4;
  localparam int MAG_WIDTH = XY_WIDTH - 1;

  // angle in 1/1024 centidegree
  localparam int ANGLE_FRAC_BITS = 10;
  localparam int Z_WIDTH         = 25;
  localparam int FULL_TURN       = 36000;
  localparam int QUARTER_TURN    = 9000;
  localparam int REM_WIDTH       = 14;
  localparam int ANGLE_BIAS      = 2 * FULL_TURN;
  localparam int ANGLE_U_WIDTH   = 18;

  // CORDIC gain compensation, Q30
  localparam int GAIN_SHIFT = 30;
  localparam logic [GAIN_SHIFT-1:0] GAIN_Q30 = 30'd652032874;

  localparam int CFG_INDEX_WIDTH = 1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CENTER_X = 1'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CENTER_Y = 1'd1;

  typedef struct packed {
    logic                       valid;
    logic signed [XY_WIDTH-1:0] x;
    logic signed [XY_WIDTH-1:0] y;
    logic signed [Z_WIDTH-1:0]  z;
  } cord_t;

  // atan(2^-k) in 1/1024 centidegree, rounded to nearest
  function automatic logic signed [Z_WIDTH-1:0] atan_step(input int k);
    logic signed [Z_WIDTH-1:0] a;
    case (k)
      0:       a = 25'sd4608000;
      1:       a = 25'sd2720261;
      2:       a = 25'sd1437311;
      3:       a = 25'sd729602;
      4:       a = 25'sd366217;
      5:       a = 25'sd183287;
      6:       a = 25'sd91666;
      7:       a = 25'sd45836;
      8:       a = 25'sd22918;
      9:       a = 25'sd11459;
      10:      a = 25'sd5730;
      11:      a = 25'sd2865;
      12:      a = 25'sd1432;
      13:      a = 25'sd716;
      14:      a = 25'sd358;
      15:      a = 25'sd179;
      16:      a = 25'sd90;
      17:      a = 25'sd45;
      18:      a = 25'sd22;
      19:      a = 25'sd11;
      20:      a = 25'sd6;
      21:      a = 25'sd3;
      22:      a = 25'sd1;
      23:      a = 25'sd1;
      default: a = 25'sd0;
    endcase
    return a;
  endfunction

endpackage

FILE: hw/rtl/prc_point_if.sv
`timescale 1ns / 1ps
// Point request channel: valid/ready with the point and the rotation angle.
interface prc_point_if import prc_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [ANGLE_WIDTH-1:0] angle_centideg;

  modport source (output valid, output point_x, output point_y, output angle_centideg,
                  input ready);
  modport sink   (input valid, input point_x, input point_y, input angle_centideg,
                  output ready);
endinterface

FILE: hw/rtl/prc_result_if.sv
`timescale 1ns / 1ps
// Result channel: valid/ready with the rotated point and the clip flag.
interface prc_result_if import prc_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] rotated_x;
  logic signed [COORD_WIDTH-1:0] rotated_y;
  logic                          saturated;

  modport source (output valid, output rotated_x, output rotated_y, output saturated,
                  input ready);
  modport sink   (input valid, input rotated_x, input rotated_y, input saturated,
                  output ready);
endinterface

FILE: hw/rtl/prc_prep.sv
`timescale 1ns / 1ps
// Front stage: offsets from the center, angle reduction, quarter turns and CORDIC seed.
module prc_prep import prc_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  prc_point_if.sink                     pt,
  input  logic signed [COORD_WIDTH-1:0] center_x,
  input  logic signed [COORD_WIDTH-1:0] center_y,
  output cord_t                         out_d,
  input  logic                          out_ready
);

  localparam int GUARD = GUARD_SUM - COORD_WIDTH;
  localparam int DW    = COORD_WIDTH + 1;
  localparam int XPAD  = XY_WIDTH - DW - GUARD;
  localparam int ZPAD  = Z_WIDTH - REM_WIDTH - ANGLE_FRAC_BITS;

  logic                    valid;
  logic signed [DW-1:0]    dx;
  logic signed [DW-1:0]    dy;
  logic [1:0]              quarter;
  logic [REM_WIDTH-1:0]    rem;
  logic                    ready;

  logic [ANGLE_U_WIDTH-1:0] r0, r1, r2, r3, r4;
  logic [3:0]               quo;
  logic signed [DW-1:0]     qx, qy;

  assign ready    = !valid || out_ready;
  assign pt.ready = ready;

  // angle + 2 turns is positive; a restoring divide by 9000 gives
  // the quarter count (mod 4) and the remainder
  always_comb begin
    r0     = {pt.angle_centideg[ANGLE_WIDTH-1], pt.angle_centideg}
             + ANGLE_U_WIDTH'(ANGLE_BIAS);
    quo[3] = (r0 >= ANGLE_U_WIDTH'(8 * QUARTER_TURN));
    r1     = quo[3] ? r0 - ANGLE_U_WIDTH'(8 * QUARTER_TURN) : r0;
    quo[2] = (r1 >= ANGLE_U_WIDTH'(4 * QUARTER_TURN));
    r2     = quo[2] ? r1 - ANGLE_U_WIDTH'(4 * QUARTER_TURN) : r1;
    quo[1] = (r2 >= ANGLE_U_WIDTH'(2 * QUARTER_TURN));
    r3     = quo[1] ? r2 - ANGLE_U_WIDTH'(2 * QUARTER_TURN) : r2;
    quo[0] = (r3 >= ANGLE_U_WIDTH'(QUARTER_TURN));
    r4     = quo[0] ? r3 - ANGLE_U_WIDTH'(QUARTER_TURN) : r3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= pt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && pt.valid) begin
      dx      <= {pt.point_x[COORD_WIDTH-1], pt.point_x} - {center_x[COORD_WIDTH-1], center_x};
      dy      <= {pt.point_y[COORD_WIDTH-1], pt.point_y} - {center_y[COORD_WIDTH-1], center_y};
      quarter <= quo[1:0];
      rem     <= r4[REM_WIDTH-1:0];
    end
  end

  // clockwise quarter turn: (x, y) -> (y, -x)
  always_comb begin
    case (quarter)
      2'd0: begin
        qx = dx;
        qy = dy;
      end
      2'd1: begin
        qx = dy;
        qy = -dx;
      end
      2'd2: begin
        qx = -dx;
        qy = -dy;
      end
      2'd3: begin
        qx = -dy;
        qy = dx;
      end
      default: begin
        qx = dx;
        qy = dy;
      end
    endcase
  end

  assign out_d = {valid,
                  {{XPAD{qx[DW-1]}}, qx, {GUARD{1'b0}}},
                  {{XPAD{qy[DW-1]}}, qy, {GUARD{1'b0}}},
                  {{ZPAD{1'b0}}, rem, {ANGLE_FRAC_BITS{1'b0}}}};

endmodule

FILE: hw/rtl/prc_cell.sv
`timescale 1ns / 1ps
// One CORDIC rotation step with its own pipeline register.
module prc_cell import prc_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  cord_t in_d,
  output logic  in_ready,
  output cord_t out_d,
  input  logic  out_ready
);

  logic                       valid;
  logic signed [XY_WIDTH-1:0] x;
  logic signed [XY_WIDTH-1:0] y;
  logic signed [Z_WIDTH-1:0]  z;

  logic signed [XY_WIDTH-1:0] xi, yi, xs, ys;
  logic signed [Z_WIDTH-1:0]  zi, ang;

  assign in_ready = !valid || out_ready;

  assign xi  = in_d.x;
  assign yi  = in_d.y;
  assign zi  = in_d.z;
  assign xs  = xi >>> STEP;
  assign ys  = yi >>> STEP;
  assign ang = atan_step(STEP);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_d.valid) begin
      if (!zi[Z_WIDTH-1]) begin
        x <= xi + ys;
        y <= yi - xs;
        z <= zi - ang;
      end else begin
        x <= xi - ys;
        y <= yi + xs;
        z <= zi + ang;
      end
    end
  end

  assign out_d = {valid, x, y, z};

endmodule

FILE: hw/rtl/prc_post.sv
`timescale 1ns / 1ps
// Back end: gain removal, rounding out the guard bits, center add-back and saturation.
module prc_post import prc_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cord_t                         in_d,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] center_x,
  input  logic signed [COORD_WIDTH-1:0] center_y,
  prc_result_if.source                  res
);

  localparam int GUARD  = GUARD_SUM - COORD_WIDTH;
  localparam int HI_W   = MAG_WIDTH;
  localparam int LO_W   = 2 * GAIN_SHIFT;
  localparam int SUM_W  = MAG_WIDTH + 1;
  localparam int Q_W    = SUM_W - GUARD;
  localparam int S_W    = Q_W + 2;
  localparam int TOP_W  = S_W - COORD_WIDTH;

  // stage 1: magnitude and sign
  logic                  s1_valid;
  logic                  s1_neg_x, s1_neg_y;
  logic [MAG_WIDTH-1:0]  s1_ux, s1_uy;
  // stage 2: partial products
  logic                  s2_valid;
  logic                  s2_neg_x, s2_neg_y;
  logic [HI_W-1:0]       s2_hi_x, s2_hi_y;
  logic [LO_W-1:0]       s2_lo_x, s2_lo_y;
  // stage 3: rounded magnitude without guard bits
  logic                  s3_valid;
  logic                  s3_neg_x, s3_neg_y;
  logic [Q_W-1:0]        s3_qx, s3_qy;
  // stage 4 is the result register
  logic                  s4_valid;
  logic signed [COORD_WIDTH-1:0] s4_rx, s4_ry;
  logic                  s4_sat;

  logic r1, r2, r3, r4;

  logic signed [XY_WIDTH-1:0] xi, yi;
  logic [SUM_W-1:0]           px, py;
  logic signed [Q_W:0]        vx, vy;
  logic [S_W-1:0]             tx, ty;
  logic                       hi_x, lo_x, hi_y, lo_y;
  logic [COORD_WIDTH-1:0]     ox, oy;

  assign r4       = !s4_valid || res.ready;
  assign r3       = !s3_valid || r4;
  assign r2       = !s2_valid || r3;
  assign r1       = !s1_valid || r2;
  assign in_ready = r1;

  assign xi = in_d.x;
  assign yi = in_d.y;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      if (r1) s1_valid <= in_d.valid;
      if (r2) s2_valid <= s1_valid;
      if (r3) s3_valid <= s2_valid;
      if (r4) s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && in_d.valid) begin
      s1_neg_x <= xi[XY_WIDTH-1];
      s1_neg_y <= yi[XY_WIDTH-1];
      s1_ux    <= MAG_WIDTH'(xi[XY_WIDTH-1] ? -xi : xi);
      s1_uy    <= MAG_WIDTH'(yi[XY_WIDTH-1] ? -yi : yi);
    end
  end

  always_ff @(posedge clk) begin
    if (r2 && s1_valid) begin
      s2_neg_x <= s1_neg_x;
      s2_neg_y <= s1_neg_y;
      s2_hi_x  <= HI_W'(s1_ux[MAG_WIDTH-1:GAIN_SHIFT]) * HI_W'(GAIN_Q30);
      s2_hi_y  <= HI_W'(s1_uy[MAG_WIDTH-1:GAIN_SHIFT]) * HI_W'(GAIN_Q30);
      s2_lo_x  <= LO_W'(s1_ux[GAIN_SHIFT-1:0]) * LO_W'(GAIN_Q30);
      s2_lo_y  <= LO_W'(s1_uy[GAIN_SHIFT-1:0]) * LO_W'(GAIN_Q30);
    end
  end

  // gain product truncated, then half away from zero on the guard bits
  assign px = SUM_W'(s2_hi_x) + SUM_W'(s2_lo_x[LO_W-1:GAIN_SHIFT])
              + (SUM_W'(1) << (GUARD - 1));
  assign py = SUM_W'(s2_hi_y) + SUM_W'(s2_lo_y[LO_W-1:GAIN_SHIFT])
              + (SUM_W'(1) << (GUARD - 1));

  always_ff @(posedge clk) begin
    if (r3 && s2_valid) begin
      s3_neg_x <= s2_neg_x;
      s3_neg_y <= s2_neg_y;
      s3_qx    <= px[SUM_W-1:GUARD];
      s3_qy    <= py[SUM_W-1:GUARD];
    end
  end

  always_comb begin
    vx   = s3_neg_x ? -$signed({1'b0, s3_qx}) : $signed({1'b0, s3_qx});
    vy   = s3_neg_y ? -$signed({1'b0, s3_qy}) : $signed({1'b0, s3_qy});
    tx   = {vx[Q_W], vx} + {{TOP_W{center_x[COORD_WIDTH-1]}}, center_x};
    ty   = {vy[Q_W], vy} + {{TOP_W{center_y[COORD_WIDTH-1]}}, center_y};
    // out of range when bits from the coordinate's sign up differ from the sign
    hi_x = !tx[S_W-1] && (tx[S_W-2:COORD_WIDTH-1] != '0);
    lo_x = tx[S_W-1] && (tx[S_W-2:COORD_WIDTH-1] != '1);
    hi_y = !ty[S_W-1] && (ty[S_W-2:COORD_WIDTH-1] != '0);
    lo_y = ty[S_W-1] && (ty[S_W-2:COORD_WIDTH-1] != '1);
    ox   = hi_x ? {1'b0, {(COORD_WIDTH-1){1'b1}}} :
           lo_x ? {1'b1, {(COORD_WIDTH-1){1'b0}}} : tx[COORD_WIDTH-1:0];
    oy   = hi_y ? {1'b0, {(COORD_WIDTH-1){1'b1}}} :
           lo_y ? {1'b1, {(COORD_WIDTH-1){1'b0}}} : ty[COORD_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (r4 && s3_valid) begin
      s4_rx  <= ox;
      s4_ry  <= oy;
      s4_sat <= hi_x || lo_x || hi_y || lo_y;
    end
  end

  assign res.valid     = s4_valid;
  assign res.rotated_x = s4_rx;
  assign res.rotated_y = s4_ry;
  assign res.saturated = s4_sat;

endmodule

FILE: hw/rtl/point_rotate_about_center.sv
`timescale 1ns / 1ps
// Top level: clockwise rotation of Q16.16 points about a configured center.
//
//   channel  dir  handshake      payload
//   pt       in   valid/ready    point_x, point_y, angle_centideg
//   res      out  valid/ready    rotated_x, rotated_y, saturated
//   cfg      in   cfg_wr_en      cfg_index, cfg_wr_data (center_x, center_y)
//
// One point per cycle while the result side does not stall. The pipeline is
// one front stage, a row of 24 CORDIC cells, and four back-end stages (abs,
// gain multiply, round, add/clip). Every stage holds its own valid bit, so a
// stalled result only stops the stages behind it that are full; bubbles close
// up. Synchronous reset clears all valid bits and both center registers.
module point_rotate_about_center import prc_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  prc_point_if.sink                  pt,
  prc_result_if.source               res,
  input  logic                       cfg_wr_en,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [COORD_WIDTH-1:0]     cfg_wr_data
);

  logic signed [COORD_WIDTH-1:0] center_x;
  logic signed [COORD_WIDTH-1:0] center_y;

  cord_t chain [CORDIC_STEPS+1];
  logic  rdy   [CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_CENTER_X: center_x <= cfg_wr_data;
        REG_CENTER_Y: center_y <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  prc_prep #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_prep (
    .clk       (clk),
    .rst       (rst),
    .pt        (pt),
    .center_x  (center_x),
    .center_y  (center_y),
    .out_d     (chain[0]),
    .out_ready (rdy[0])
  );

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
    prc_cell #(
      .STEP (k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_d      (chain[k]),
      .in_ready  (rdy[k]),
      .out_d     (chain[k+1]),
      .out_ready (rdy[k+1])
    );
  end

  prc_post #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_post (
    .clk      (clk),
    .rst      (rst),
    .in_d     (chain[CORDIC_STEPS]),
    .in_ready (rdy[CORDIC_STEPS]),
    .center_x (center_x),
    .center_y (center_y),
    .res      (res)
  );

  localparam logic [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // the pipeline refuses a request only when every stage is full and the result stalls
  assert property (@(posedge clk) disable iff (rst)
    !pt.ready |-> (res.valid && !res.ready))
    else $error("request refused while the pipeline has room");

  // a clipped result has at least one coordinate at a range limit
  assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.saturated) |->
      (res.rotated_x == COORD_MAX || res.rotated_x == COORD_MIN ||
       res.rotated_y == COORD_MAX || res.rotated_y == COORD_MIN))
    else $error("saturated flag without a clipped coordinate");

  // no result right after reset
  assert property (@(posedge clk) $past(rst) |-> !res.valid)
    else $error("result valid after reset");

  // a newly shown result came from a valid CORDIC output, through the abs, gain multiply and round stages
  assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(chain[CORDIC_STEPS].valid, 4))
    else $error("result appeared without a CORDIC output");

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for point_rotate_about_center: directed table, random phases, fixed-point predictor.
module tb;
  import prc_pkg::*;

  localparam int CW          = COORD_WIDTH_DEF;
  localparam int GUARD       = GUARD_SUM - CW;
  localparam int ANGLE_SCALE = 1024;
  localparam int LATENCY     = 29;
  localparam int PER_PHASE   = 125;
  localparam int PHASES      = 6;
  localparam int PRESS_AFTER = 40;
  localparam int PRESS_LEN   = 300;
  localparam int DOG_LIMIT   = 2000;

  localparam longint unsigned GAIN_FIX = 64'd652032874;
  localparam longint unsigned MASK30   = (64'd1 << 30) - 64'd1;

  localparam logic signed [CW-1:0] CMAX = 32'sh7fff_ffff;
  localparam logic signed [CW-1:0] CMIN = 32'sh8000_0000;
  localparam logic signed [CW-1:0] ONE  = 32'sh0001_0000;

  // atan(2^-k) in 1/1024 centidegree
  localparam int ATAN_UNITS [CORDIC_STEPS] = '{
    4608000, 2720261, 1437311, 729602, 366217, 183287, 91666, 45836,
    22918, 11459, 5730, 2865, 1432, 716, 358, 179,
    90, 45, 22, 11, 6, 3, 1, 1
  };

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 sat;
  } rot_t;

  typedef struct packed {
    logic signed [CW-1:0]          cx;
    logic signed [CW-1:0]          cy;
    logic signed [CW-1:0]          px;
    logic signed [CW-1:0]          py;
    logic signed [ANGLE_WIDTH-1:0] ang;
    logic                          typed;
    rot_t                          want;
  } row_t;

  // typed results only where the point sits on the center
  localparam int NROWS = 22;
  localparam row_t DIR_ROWS [NROWS] = '{
    '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 17'sd0,     1'b1, '{32'sd0, 32'sd0, 1'b0}},
    '{32'sd0, 32'sd0, ONE,    32'sd0, 17'sd0,     1'b0, '0},
    '{32'sd0, 32'sd0, ONE,    32'sd0, 17'sd9000,  1'b0, '0},
    '{32'sd0, 32'sd0, ONE,    32'sd0, 17'sd18000, 1'b0, '0},
    '{32'sd0, 32'sd0, ONE,    32'sd0, 17'sd27000, 1'b0, '0},
    '{32'sd0, 32'sd0, ONE,    ONE,    17'sd4500,  1'b0, '0},
    '{32'sd0, 32'sd0, 32'sd0, ONE,    -17'sd9000, 1'b0, '0},
    '{32'sd0, 32'sd0, ONE,    ONE,    17'sd36000, 1'b0, '0},
    '{32'sd0, 32'sd0, ONE,    ONE,   -17'sd36000, 1'b0, '0},
    '{32'sd0, 32'sd0, ONE,    32'sd0, 17'sh0ffff, 1'b0, '0},
    '{32'sd0, 32'sd0, ONE,    32'sd0, 17'sh10000, 1'b0, '0},
    '{32'sd0, 32'sd0, CMAX,   CMAX,   17'sd4500,  1'b0, '0},
    '{32'sd0, 32'sd0, CMIN,   CMIN,   17'sd18000, 1'b0, '0},
    '{32'sd0, 32'sd0, CMIN,   CMAX,   17'sd8999,  1'b0, '0},
    '{32'sd0, 32'sd0, CMAX,   CMIN,   17'sd1,     1'b0, '0},
    '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 17'sh10000, 1'b1, '{32'sd0, 32'sd0, 1'b0}},
    '{CMAX,   CMIN,   CMAX,   CMIN,   17'sd12345, 1'b1, '{CMAX, CMIN, 1'b0}},
    '{CMAX,   CMIN,   CMIN,   CMAX,   17'sd18000, 1'b0, '0},
    '{CMAX,   CMIN,   32'sd0, 32'sd0, 17'sd9000,  1'b0, '0},
    '{CMIN,   CMAX,   CMIN,   CMAX,   -17'sd1,    1'b1, '{CMIN, CMAX, 1'b0}},
    '{CMIN,   CMAX,   CMAX,   CMIN,   17'sd27000, 1'b0, '0},
    '{CMIN,   CMAX,   ONE,    -ONE,   17'sd35999, 1'b0, '0}
  };

  logic                       clk;
  logic                       rst;
  logic                       cfg_wr_en;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [CW-1:0]              cfg_wr_data;

  prc_point_if  #(.COORD_WIDTH(CW)) pt_ch ();
  prc_result_if #(.COORD_WIDTH(CW)) res_ch ();

  point_rotate_about_center #(.COORD_WIDTH(CW)) dut (
    .clk         (clk),
    .rst         (rst),
    .pt          (pt_ch),
    .res         (res_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data)
  );

  // predictor's copy of the center registers
  logic signed [CW-1:0] ctr_x = '0;
  logic signed [CW-1:0] ctr_y = '0;

  rot_t rot_due [$];
  int   mismatch_count = 0;
  int   results_taken  = 0;
  bit   idle_on        = 1'b0;

  function automatic longint unscale(longint v);
    longint unsigned mag, prod, q;
    mag  = (v < 0) ? -v : v;
    prod = (mag >> 30) * GAIN_FIX + (((mag & MASK30) * GAIN_FIX) >> 30);
    q    = (prod + (64'd1 << (GUARD - 1))) >> GUARD;
    return (v < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [CW-1:0] clip_coord(longint v, inout logic hit);
    longint hi, lo;
    hi = (longint'(1) <<< (CW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      hit = 1'b1;
      return hi[CW-1:0];
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo[CW-1:0];
    end
    return v[CW-1:0];
  endfunction

  // clockwise turn about the center: quarter turns exact, remainder by CORDIC
  function automatic rot_t rotate_cw(logic signed [CW-1:0] px, logic signed [CW-1:0] py,
                                     logic signed [ANGLE_WIDTH-1:0] ang);
    longint dx, dy, x, y, xs, ys, swap;
    int     turn, quarters, rem, z, k;
    rot_t   r;
    dx   = longint'(px) - longint'(ctr_x);
    dy   = longint'(py) - longint'(ctr_y);
    turn = int'(ang) % FULL_TURN;
    if (turn < 0) turn += FULL_TURN;
    quarters = turn / QUARTER_TURN;
    rem      = turn % QUARTER_TURN;
    for (k = 0; k < quarters; k++) begin
      swap = dx;
      dx   = dy;
      dy   = -swap;
    end
    x = dx <<< GUARD;
    y = dy <<< GUARD;
    z = rem * ANGLE_SCALE;
    for (k = 0; k < CORDIC_STEPS; k++) begin
      xs = x >>> k;
      ys = y >>> k;
      if (z >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z - ATAN_UNITS[k];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z + ATAN_UNITS[k];
      end
    end
    r.sat = 1'b0;
    r.x   = clip_coord(unscale(x) + longint'(ctr_x), r.sat);
    r.y   = clip_coord(unscale(y) + longint'(ctr_y), r.sat);
    return r;
  endfunction

  function automatic logic signed [CW-1:0] small_coord();
    return CW'(int'($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000);
  endfunction

  function automatic logic signed [CW-1:0] rand_coord(logic signed [CW-1:0] near);
    case ($urandom_range(0, 7))
      0:       return CMAX;
      1:       return CMIN;
      2, 3:    return $urandom;
      4:       return near + CW'(int'($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000);
      default: return small_coord();
    endcase
  endfunction

  function automatic logic signed [ANGLE_WIDTH-1:0] rand_angle();
    int a;
    case ($urandom_range(0, 5))
      0:       a = int'($urandom);
      1:       a = int'($urandom_range(0, 8)) * QUARTER_TURN - FULL_TURN
                   + int'($urandom_range(0, 2)) - 1;
      default: a = int'($urandom_range(0, 2 * FULL_TURN)) - FULL_TURN;
    endcase
    return ANGLE_WIDTH'(a);
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR @%0t: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic check_result();
    rot_t want;
    results_taken++;
    if (rot_due.size() == 0) begin
      report_mismatch($sformatf("unexpected result x=%h y=%h sat=%b",
                                res_ch.rotated_x, res_ch.rotated_y, res_ch.saturated));
    end else begin
      want = rot_due.pop_front();
      if (res_ch.rotated_x !== want.x)
        report_mismatch($sformatf("rotated_x %h, want %h", res_ch.rotated_x, want.x));
      if (res_ch.rotated_y !== want.y)
        report_mismatch($sformatf("rotated_y %h, want %h", res_ch.rotated_y, want.y));
      if (res_ch.saturated !== want.sat)
        report_mismatch($sformatf("saturated %b, want %b", res_ch.saturated, want.sat));
    end
  endtask

  // request side: optional idle burst, then hold valid until ready
  task automatic send_point(input logic signed [CW-1:0] px, input logic signed [CW-1:0] py,
                            input logic signed [ANGLE_WIDTH-1:0] ang,
                            input logic typed, input rot_t want);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      pt_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    pt_ch.valid          <= 1'b1;
    pt_ch.point_x        <= px;
    pt_ch.point_y        <= py;
    pt_ch.angle_centideg <= ang;
    @(posedge clk);
    while (!pt_ch.ready) @(posedge clk);
    rot_due.push_back(typed ? want : rotate_cw(px, py, ang));
  endtask

  task automatic drain();
    while (rot_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 6) @(posedge clk);
  endtask

  task automatic set_center(input logic signed [CW-1:0] cx, input logic signed [CW-1:0] cy);
    pt_ch.valid <= 1'b0;
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_index   <= REG_CENTER_X;
    cfg_wr_data <= cx;
    @(posedge clk);
    cfg_index   <= REG_CENTER_Y;
    cfg_wr_data <= cy;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    ctr_x = cx;
    ctr_y = cy;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: random stalls, one long hold to back the pipe up
  initial begin
    int  hold_left;
    bit  press_done;
    hold_left  = 0;
    press_done = 1'b0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (res_ch.valid && res_ch.ready) check_result();
      if (rst) begin
        res_ch.ready <= 1'b0;
      end else if (!press_done && results_taken == PRESS_AFTER) begin
        press_done = 1'b1;
        hold_left  = PRESS_LEN;
        res_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(0, 14);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog: cycles without any transfer on either channel
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (rst || (pt_ch.valid && pt_ch.ready) || (res_ch.valid && res_ch.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= DOG_LIMIT) begin
        $display("ERROR @%0t: no transfer for %0d cycles", $time, DOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic signed [CW-1:0] nx, ny;
    int                   i, ph, n;
    rst                  <= 1'b1;
    cfg_wr_en            <= 1'b0;
    cfg_index            <= REG_CENTER_X;
    cfg_wr_data          <= '0;
    pt_ch.valid          <= 1'b0;
    pt_ch.point_x        <= '0;
    pt_ch.point_y        <= '0;
    pt_ch.angle_centideg <= '0;
    repeat (11) @(posedge clk);
    rst     <= 1'b0;
    idle_on <= 1'b1;
    @(posedge clk);

    for (i = 0; i < NROWS; i++) begin
      if (DIR_ROWS[i].cx != ctr_x || DIR_ROWS[i].cy != ctr_y)
        set_center(DIR_ROWS[i].cx, DIR_ROWS[i].cy);
      send_point(DIR_ROWS[i].px, DIR_ROWS[i].py, DIR_ROWS[i].ang,
                 DIR_ROWS[i].typed, DIR_ROWS[i].want);
    end

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        1:       begin nx = CMIN;     ny = CMIN;     end
        2:       begin nx = $urandom; ny = $urandom; end
        3:       begin nx = CMAX;     ny = CMAX;     end
        4:       begin nx = '0;       ny = '0;       end
        default: begin nx = small_coord(); ny = small_coord(); end
      endcase
      // no idling in the third phase and in the closing one
      idle_on <= (ph != 2) && (ph != PHASES - 1);
      set_center(nx, ny);
      for (n = 0; n < PER_PHASE; n++)
        send_point(rand_coord(ctr_x), rand_coord(ctr_y), rand_angle(), 1'b0, '0);
    end
    pt_ch.valid <= 1'b0;

    drain();
    if (rot_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", rot_due.size()));
    if (mismatch_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: point_rotate_about_center.f
hw/rtl/prc_pkg.sv
hw/rtl/prc_point_if.sv
hw/rtl/prc_result_if.sv
hw/rtl/prc_prep.sv
hw/rtl/prc_cell.sv
hw/rtl/prc_post.sv
hw/rtl/point_rotate_about_center.sv
test/tb.sv
